/* rtl/core/scdr_pkg.sv */
// Shared widths, item codes and sequencer states for the continuity density rate block.
package scdr_pkg;

    // Parameter defaults handed to the top level.
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int DIMENSIONS_DEF    = 3;
    localparam int FRAC_DEF          = 12;

    // Field widths of the channels.
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int MASS_W  = 24;
    localparam int VEC_W   = 24;
    localparam int RATE_W  = 48;

    // Internal arithmetic widths.
    localparam int DV_W    = VEC_W + 1;          // velocity difference
    localparam int DOT_W   = 2 * VEC_W + 2;      // sum of three products
    localparam int MAG_W   = DOT_W - 1;          // magnitude of the shifted dot product
    localparam int MUL_A_W = DV_W + 1;
    localparam int MUL_B_W = VEC_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int LO_W    = MASS_W;             // low part of the magnitude
    localparam int HI_W    = MAG_W - LO_W;       // high part of the magnitude
    localparam int CPROD_W = RATE_W + 1;         // clamped product, at most 2^48
    localparam int FULL_W  = CPROD_W + 1;
    localparam int SUM_W   = RATE_W + 3;
    localparam int PW      = MASS_W + 3 * VEC_W; // particle word: mass, vx, vy, vz

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAIR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAIR_RA,
        ST_PAIR_RB,
        ST_DOT,
        ST_DOT_END,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_CLAMP,
        ST_ACC,
        ST_READ,
        ST_RESP
    } state_t;

endpackage

/* rtl/core/scdr_ifs.sv */
// Channel interfaces: item requests, result replies and the particle count write port.
interface scdr_req_if;
    logic                                valid;
    logic                                ready;
    logic [scdr_pkg::KIND_W-1:0]         kind;
    logic [scdr_pkg::IDX_W-1:0]          first_index;
    logic [scdr_pkg::IDX_W-1:0]          second_index;
    logic [scdr_pkg::MASS_W-1:0]         particle_mass_in;
    logic signed [scdr_pkg::VEC_W-1:0]   vector_x;
    logic signed [scdr_pkg::VEC_W-1:0]   vector_y;
    logic signed [scdr_pkg::VEC_W-1:0]   vector_z;
    logic                                end_of_pairs;

    modport source (
        output valid, kind, first_index, second_index, particle_mass_in,
               vector_x, vector_y, vector_z, end_of_pairs,
        input  ready
    );
    modport sink (
        input  valid, kind, first_index, second_index, particle_mass_in,
               vector_x, vector_y, vector_z, end_of_pairs,
        output ready
    );
endinterface

interface scdr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic signed [scdr_pkg::RATE_W-1:0]  rate;
    logic                                pairs_done;

    modport source (output valid, status, rate, pairs_done, input ready);
    modport sink   (input  valid, status, rate, pairs_done, output ready);
endinterface

interface scdr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [scdr_pkg::CNT_W-1:0]          particle_count;

    modport source (output valid, particle_count, input ready);
    modport sink   (input  valid, particle_count, output ready);
endinterface

/* rtl/core/sph_continuity_density_rate_top.sv */
// Top level: continuity density rate accumulator over particle and accumulator memories.
// One item is in work at a time. Pairs run through the single shared multiplier and the
// two read-modify-writes on the single-port accumulator memory. Reset clears control
// state and sets the particle count to 1024; the memories are not cleared and hold
// nothing defined until loaded.
module sph_continuity_density_rate_top #(
    parameter int MAX_PARTICLES = scdr_pkg::MAX_PARTICLES_DEF,
    parameter int DIMENSIONS    = scdr_pkg::DIMENSIONS_DEF,
    parameter int FRAC          = scdr_pkg::FRAC_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    scdr_req_if.sink    req,
    scdr_rsp_if.source  rsp,
    scdr_cfg_if.sink    cfg
);

    localparam int AW  = $clog2(MAX_PARTICLES);
    localparam int DCW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    // The particle memory holds mass and velocity in one word, the accumulator
    // memory holds the 48-bit rates. Both have registered read data.
    logic [scdr_pkg::PW-1:0]     part_mem [MAX_PARTICLES];
    logic [scdr_pkg::RATE_W-1:0] acc_mem  [MAX_PARTICLES];

    logic [scdr_pkg::PW-1:0]     pm_rdata_reg;
    logic [scdr_pkg::RATE_W-1:0] am_rdata_reg;

    scdr_pkg::state_t state_reg, state_next;

    logic [scdr_pkg::CNT_W-1:0] count_reg;

    // Captured item.
    logic [scdr_pkg::KIND_W-1:0]       kind_reg;
    logic [AW-1:0]                     a_reg;
    logic [AW-1:0]                     b_reg;
    logic [scdr_pkg::MASS_W-1:0]       mass_in_reg;
    logic signed [scdr_pkg::VEC_W-1:0] gx_reg, gy_reg, gz_reg;
    logic                              eop_reg;
    logic                              ok_reg;

    // Pair datapath.
    logic [scdr_pkg::PW-1:0]             pa_reg;
    logic [DCW-1:0]                      dim_cnt_reg;
    logic signed [scdr_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [scdr_pkg::DOT_W-1:0]   dot_reg;
    logic [scdr_pkg::MAG_W-1:0]          mag_reg;
    logic                                neg_reg;
    logic                                side_reg;
    logic [scdr_pkg::RATE_W-1:0]         prod_lo_reg;
    logic [scdr_pkg::CPROD_W-1:0]        cprod_reg;

    // Output register.
    logic                              out_valid_reg;
    logic                              out_status_reg;
    logic [scdr_pkg::RATE_W-1:0]       out_rate_reg;
    logic                              out_done_reg;

    // Memory controls from the sequencer.
    logic                        pm_re, pm_we;
    logic [AW-1:0]               pm_raddr;
    logic                        am_re, am_we;
    logic [AW-1:0]               am_raddr;
    logic [scdr_pkg::RATE_W-1:0] am_wdata;

    // Shared multiplier operands.
    logic signed [scdr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [scdr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [scdr_pkg::MUL_P_W-1:0] mul_p;

    logic accept;
    logic resp_load;
    logic a_ok, b_ok, item_ok;

    logic [scdr_pkg::VEC_W-1:0]        va, vb;
    logic signed [scdr_pkg::VEC_W-1:0] g_sel;
    logic signed [scdr_pkg::DV_W-1:0]  dv;
    logic [scdr_pkg::MASS_W-1:0]       mass_sel;

    logic signed [scdr_pkg::DOT_W-1:0] dot_sh;
    logic [scdr_pkg::DOT_W-1:0]        dot_abs;
    logic [scdr_pkg::MAG_W-1:0]        p_hi;
    logic [scdr_pkg::FULL_W-1:0]       full_prod;
    logic                              clamp_hi;
    logic signed [scdr_pkg::SUM_W-1:0] acc_ext, cp_ext, acc_sum;
    logic [scdr_pkg::RATE_W-1:0]       acc_sat;

    localparam logic [scdr_pkg::FULL_W-1:0] PROD_LIMIT =
        scdr_pkg::FULL_W'(1) << scdr_pkg::RATE_W;

    // The block takes a new transaction whenever the sequencer is idle; a finished
    // result may still wait in the output register at that time.
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == scdr_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.rate       = out_rate_reg;
    assign rsp.pairs_done = out_done_reg;

    // An index is usable only below the particle count and below the memory depth.
    assign a_ok = ({1'b0, req.first_index} < count_reg) &&
                  (32'(req.first_index) < MAX_PARTICLES);
    assign b_ok = ({1'b0, req.second_index} < count_reg) &&
                  (32'(req.second_index) < MAX_PARTICLES);

    always_comb
    begin
        case (req.kind)
            scdr_pkg::KIND_LOAD: item_ok = a_ok;
            scdr_pkg::KIND_PAIR: item_ok = a_ok && b_ok;
            scdr_pkg::KIND_READ: item_ok = a_ok;
            default:             item_ok = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= scdr_pkg::COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            count_reg <= cfg.particle_count;
        end
    end

    // Particle memory: written on a load, read twice for a pair.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            part_mem[a_reg] <= {mass_in_reg, gx_reg, gy_reg, gz_reg};
        end
        if (pm_re)
        begin
            pm_rdata_reg <= part_mem[pm_raddr];
        end
    end

    // Accumulator memory: cleared per entry on a load, read-modify-written on a pair.
    always_ff @(posedge clk)
    begin
        if (am_we)
        begin
            acc_mem[am_raddr] <= am_wdata;
        end
        if (am_re)
        begin
            am_rdata_reg <= acc_mem[am_raddr];
        end
    end

    // Velocity component and gradient for the dimension in work. The particle a
    // word sits in pa_reg, the particle b word stays in the read data register.
    always_comb
    begin
        case (2'(dim_cnt_reg))
            2'd0:
            begin
                va    = pa_reg[71:48];
                vb    = pm_rdata_reg[71:48];
                g_sel = gx_reg;
            end
            2'd1:
            begin
                va    = pa_reg[47:24];
                vb    = pm_rdata_reg[47:24];
                g_sel = gy_reg;
            end
            default:
            begin
                va    = pa_reg[23:0];
                vb    = pm_rdata_reg[23:0];
                g_sel = gz_reg;
            end
        endcase
    end

    assign dv = $signed({va[scdr_pkg::VEC_W-1], va}) - $signed({vb[scdr_pkg::VEC_W-1], vb});

    // Accumulator i is scaled by mass(j) first, accumulator j by mass(i) next.
    assign mass_sel = side_reg ? pa_reg[95:72] : pm_rdata_reg[95:72];

    // One multiplier serves the dot product terms and both halves of each mass product.
    always_comb
    begin
        case (state_reg)
            scdr_pkg::ST_DOT:
            begin
                mul_a = {dv[scdr_pkg::DV_W-1], dv};
                mul_b = {g_sel[scdr_pkg::VEC_W-1], g_sel};
            end
            scdr_pkg::ST_MUL_LO:
            begin
                mul_a = $signed(scdr_pkg::MUL_A_W'(mag_reg[scdr_pkg::LO_W-1:0]));
                mul_b = $signed({1'b0, mass_sel});
            end
            default:
            begin
                mul_a = $signed(scdr_pkg::MUL_A_W'(mag_reg[scdr_pkg::MAG_W-1:scdr_pkg::LO_W]));
                mul_b = $signed({1'b0, mass_sel});
            end
        endcase
    end

    assign mul_p = scdr_pkg::MUL_P_W'(mul_a) * scdr_pkg::MUL_P_W'(mul_b);

    // The arithmetic shift is the floor division by 2^FRAC.
    assign dot_sh  = dot_reg >>> FRAC;
    assign dot_abs = dot_sh[scdr_pkg::DOT_W-1] ? scdr_pkg::DOT_W'(-dot_sh)
                                                : scdr_pkg::DOT_W'(dot_sh);

    // Clamp the mass product at 2^48. A high partial product above 2^24 alone
    // passes the limit; otherwise the two halves are added and compared.
    assign p_hi      = prod_reg[scdr_pkg::MAG_W-1:0];
    assign clamp_hi  = (p_hi[scdr_pkg::MAG_W-1:25] != '0) ||
                       (p_hi[24] && (p_hi[23:0] != '0));
    assign full_prod = scdr_pkg::FULL_W'({p_hi[24:0], 24'd0}) +
                       scdr_pkg::FULL_W'(prod_lo_reg);

    // Signed add to the accumulator with saturation at 48 bits.
    assign acc_ext = $signed(scdr_pkg::SUM_W'($signed(am_rdata_reg)));
    assign cp_ext  = $signed(scdr_pkg::SUM_W'(cprod_reg));
    assign acc_sum = neg_reg ? (acc_ext - cp_ext) : (acc_ext + cp_ext);

    always_comb
    begin
        if (acc_sum[scdr_pkg::SUM_W-1:scdr_pkg::RATE_W-1] == '0 ||
            acc_sum[scdr_pkg::SUM_W-1:scdr_pkg::RATE_W-1] == '1)
        begin
            acc_sat = acc_sum[scdr_pkg::RATE_W-1:0];
        end
        else if (acc_sum[scdr_pkg::SUM_W-1])
        begin
            acc_sat = {1'b1, {(scdr_pkg::RATE_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(scdr_pkg::RATE_W-1){1'b1}}};
        end
    end

    assign resp_load = (state_reg == scdr_pkg::ST_RESP) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state and memory controls.
    always_comb
    begin
        state_next = state_reg;
        pm_re      = 1'b0;
        pm_we      = 1'b0;
        pm_raddr   = a_reg;
        am_re      = 1'b0;
        am_we      = 1'b0;
        am_raddr   = side_reg ? b_reg : a_reg;
        am_wdata   = acc_sat;
        unique case (state_reg)
            scdr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!item_ok)
                    begin
                        state_next = scdr_pkg::ST_RESP;
                    end
                    else
                    begin
                        case (req.kind)
                            scdr_pkg::KIND_LOAD: state_next = scdr_pkg::ST_LOAD;
                            scdr_pkg::KIND_PAIR: state_next = scdr_pkg::ST_PAIR_RA;
                            scdr_pkg::KIND_READ: state_next = scdr_pkg::ST_READ;
                            default:             state_next = scdr_pkg::ST_RESP;
                        endcase
                    end
                end
            end
            scdr_pkg::ST_LOAD:
            begin
                pm_we      = 1'b1;
                am_we      = 1'b1;
                am_raddr   = a_reg;
                am_wdata   = '0;
                state_next = scdr_pkg::ST_RESP;
            end
            scdr_pkg::ST_PAIR_RA:
            begin
                pm_re      = 1'b1;
                state_next = scdr_pkg::ST_PAIR_RB;
            end
            scdr_pkg::ST_PAIR_RB:
            begin
                pm_re      = 1'b1;
                pm_raddr   = b_reg;
                state_next = scdr_pkg::ST_DOT;
            end
            scdr_pkg::ST_DOT:
            begin
                if (dim_cnt_reg == DCW'(DIMENSIONS - 1))
                begin
                    state_next = scdr_pkg::ST_DOT_END;
                end
            end
            scdr_pkg::ST_DOT_END:
            begin
                state_next = scdr_pkg::ST_MAG;
            end
            scdr_pkg::ST_MAG:
            begin
                state_next = scdr_pkg::ST_MUL_LO;
            end
            scdr_pkg::ST_MUL_LO:
            begin
                am_re      = 1'b1;
                state_next = scdr_pkg::ST_MUL_HI;
            end
            scdr_pkg::ST_MUL_HI:
            begin
                state_next = scdr_pkg::ST_CLAMP;
            end
            scdr_pkg::ST_CLAMP:
            begin
                state_next = scdr_pkg::ST_ACC;
            end
            scdr_pkg::ST_ACC:
            begin
                // The write lands before the second partner's read is issued,
                // so a pair with itself sees the first update.
                am_we      = 1'b1;
                state_next = side_reg ? scdr_pkg::ST_RESP : scdr_pkg::ST_MUL_LO;
            end
            scdr_pkg::ST_READ:
            begin
                am_re      = 1'b1;
                am_raddr   = a_reg;
                state_next = scdr_pkg::ST_RESP;
            end
            scdr_pkg::ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = scdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Item capture and pair datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req.kind;
            a_reg       <= AW'(req.first_index);
            b_reg       <= AW'(req.second_index);
            mass_in_reg <= req.particle_mass_in;
            gx_reg      <= req.vector_x;
            gy_reg      <= req.vector_y;
            gz_reg      <= req.vector_z;
            eop_reg     <= req.end_of_pairs;
            ok_reg      <= item_ok;
        end

        prod_reg <= mul_p;

        case (state_reg)
            scdr_pkg::ST_PAIR_RB:
            begin
                pa_reg      <= pm_rdata_reg;
                dim_cnt_reg <= '0;
            end
            scdr_pkg::ST_DOT:
            begin
                dim_cnt_reg <= dim_cnt_reg + 1'b1;
                if (dim_cnt_reg == '0)
                begin
                    dot_reg <= '0;
                end
                else
                begin
                    dot_reg <= dot_reg + $signed(prod_reg[scdr_pkg::DOT_W-1:0]);
                end
            end
            scdr_pkg::ST_DOT_END:
            begin
                dot_reg <= dot_reg + $signed(prod_reg[scdr_pkg::DOT_W-1:0]);
            end
            scdr_pkg::ST_MAG:
            begin
                mag_reg  <= dot_abs[scdr_pkg::MAG_W-1:0];
                neg_reg  <= dot_sh[scdr_pkg::DOT_W-1];
                side_reg <= 1'b0;
            end
            scdr_pkg::ST_MUL_HI:
            begin
                prod_lo_reg <= prod_reg[scdr_pkg::RATE_W-1:0];
            end
            scdr_pkg::ST_CLAMP:
            begin
                if (clamp_hi || (full_prod > PROD_LIMIT))
                begin
                    cprod_reg <= PROD_LIMIT[scdr_pkg::CPROD_W-1:0];
                end
                else
                begin
                    cprod_reg <= full_prod[scdr_pkg::CPROD_W-1:0];
                end
            end
            scdr_pkg::ST_ACC:
            begin
                side_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: loaded from the response state, held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (resp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_load)
        begin
            out_status_reg <= !ok_reg;
            out_rate_reg   <= (kind_reg == scdr_pkg::KIND_READ && ok_reg) ? am_rdata_reg : '0;
            out_done_reg   <= (kind_reg == scdr_pkg::KIND_PAIR) && eop_reg;
        end
    end

endmodule

/* tb/scdr_tb_pkg.sv */
// Transaction types and the density rate scoreboard shared by the testbench.
`timescale 1ns / 1ps

package scdr_tb_pkg;
    import scdr_pkg::*;

    // Kind code that the block accepts but does not act on.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam longint RATE_HI  = (longint'(1) <<< (RATE_W - 1)) - 1;
    localparam longint RATE_LO  = -(longint'(1) <<< (RATE_W - 1));
    localparam longint PROD_CAP = longint'(1) <<< RATE_W;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        second_index;
        logic [MASS_W-1:0]       mass;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] vz;
        logic                    end_of_pairs;
    } particle_item_t;

    typedef struct {
        logic                     status;
        logic signed [RATE_W-1:0] rate;
        logic                     pairs_done;
    } rate_reply_t;

    class density_rate_scoreboard;
        int unsigned             count_limit;
        logic [MASS_W-1:0]       mass_mem [MAX_PARTICLES_DEF];
        logic signed [VEC_W-1:0] vel_mem  [MAX_PARTICLES_DEF][3];
        longint                  acc_mem  [MAX_PARTICLES_DEF];
        rate_reply_t             replies_due[$];
        int                      errors;

        function new();
            count_limit = 32'(COUNT_RESET);
            errors      = 0;
            foreach (acc_mem[i])
            begin
                mass_mem[i]   = '0;
                vel_mem[i][0] = '0;
                vel_mem[i][1] = '0;
                vel_mem[i][2] = '0;
                acc_mem[i]    = 0;
            end
        endfunction

        function void set_count(int unsigned value);
            count_limit = value;
        endfunction

        function bit in_range(logic [IDX_W-1:0] idx);
            return 32'(idx) < count_limit && 32'(idx) < MAX_PARTICLES_DEF;
        endfunction

        // The product is clamped to 2^48 in magnitude, then the sum saturates at 48 bits.
        function void add_rate(logic [IDX_W-1:0] idx, logic [MASS_W-1:0] m, longint dot);
            longint mag;
            longint prod;
            longint sum;
            mag  = (dot < 0) ? -dot : dot;
            prod = mag * longint'(m);
            if (prod > PROD_CAP)
                prod = PROD_CAP;
            sum = acc_mem[idx] + ((dot < 0) ? -prod : prod);
            if (sum > RATE_HI)
                sum = RATE_HI;
            if (sum < RATE_LO)
                sum = RATE_LO;
            acc_mem[idx] = sum;
        endfunction

        function void predict_reply(particle_item_t it);
            rate_reply_t             want;
            logic signed [VEC_W-1:0] grad [3];
            longint                  dot;
            int                      d;
            logic [IDX_W-1:0]        a;
            logic [IDX_W-1:0]        b;
            a       = it.first_index;
            b       = it.second_index;
            grad[0] = it.vx;
            grad[1] = it.vy;
            grad[2] = it.vz;
            want.status     = 1'b0;
            want.rate       = '0;
            want.pairs_done = 1'b0;
            case (it.kind)
                KIND_LOAD:
                begin
                    if (in_range(a))
                    begin
                        mass_mem[a]   = it.mass;
                        vel_mem[a][0] = it.vx;
                        vel_mem[a][1] = it.vy;
                        vel_mem[a][2] = it.vz;
                        acc_mem[a]    = 0;
                    end
                    else
                        want.status = 1'b1;
                end
                KIND_PAIR:
                begin
                    want.pairs_done = it.end_of_pairs;
                    if (in_range(a) && in_range(b))
                    begin
                        dot = 0;
                        for (d = 0; d < DIMENSIONS_DEF; d++)
                            dot += (longint'(vel_mem[a][2'(d)]) - longint'(vel_mem[b][2'(d)]))
                                   * longint'(grad[2'(d)]);
                        dot = dot >>> FRAC_DEF;
                        add_rate(a, mass_mem[b], dot);
                        add_rate(b, mass_mem[a], dot);
                    end
                    else
                        want.status = 1'b1;
                end
                KIND_READ:
                begin
                    if (in_range(a))
                        want.rate = acc_mem[a][RATE_W-1:0];
                    else
                        want.status = 1'b1;
                end
                default:
                    ;
            endcase
            replies_due.push_back(want);
        endfunction

        function void check_reply(rate_reply_t got);
            rate_reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("reply with no transaction waiting: status %0d rate %0d pairs_done %0d",
                       got.status, got.rate, got.pairs_done);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.rate !== want.rate)
            begin
                $error("rate: expected %0d, actual %0d", want.rate, got.rate);
                errors++;
            end
            if (got.pairs_done !== want.pairs_done)
            begin
                $error("pairs_done: expected %0d, actual %0d", want.pairs_done, got.pairs_done);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

endpackage

/* tb/tb_sph_continuity_density_rate_top.sv */
// Self-checking directed and random test of the continuity density rate top level.
`timescale 1ns / 1ps

module tb_sph_continuity_density_rate_top;
    import scdr_pkg::*;
    import scdr_tb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    // Longest correct stretch without any transaction is the receiver hold below plus
    // the processing of one pair, so this limit leaves a wide margin.
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    // A pair is the slowest item the block handles.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 6;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scdr_req_if req ();
    scdr_rsp_if rsp ();
    scdr_cfg_if cfg ();

    sph_continuity_density_rate_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    density_rate_scoreboard rate_board = new();

    // Sender-side view of which particles hold defined data. Unflagged pairs and reads
    // are only generated against particles in usable_q: no undefined store entry is read.
    int unsigned count_now;
    bit          loaded [MAX_PARTICLES_DEF];
    int unsigned usable_q[$];
    int unsigned window_base;
    int          gap_odds;
    bit          quiet_tail;
    bit          hold_request;
    int unsigned quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reply side. Every reply transaction is checked against the oldest prediction.
    // Ready is stalled in random bursts, once held off for a long stretch on request,
    // and left high throughout the closing phase of the run.
    initial
    begin : reply_side
        int          stall_left;
        int          calm_left;
        rate_reply_t got;
        stall_left = 0;
        calm_left  = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.status     = rsp.status;
                got.rate       = rsp.rate;
                got.pairs_done = rsp.pairs_done;
                rate_board.check_reply(got);
            end
            if (hold_request)
            begin
                // Long hold-off: the sender keeps offering, so the block backs up.
                hold_request = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet_tail && calm_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                // Now and then a calm stretch with no stalls at all.
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(20, 80);
            end
        end
    end

    // Offers one item and returns right after the edge that accepts it. Valid stays high,
    // so a following call presents the next item without a bubble.
    task automatic send_item(input particle_item_t it);
        req.valid            <= 1'b1;
        req.kind             <= it.kind;
        req.first_index      <= it.first_index;
        req.second_index     <= it.second_index;
        req.particle_mass_in <= it.mass;
        req.vector_x         <= it.vx;
        req.vector_y         <= it.vy;
        req.vector_z         <= it.vz;
        req.end_of_pairs     <= it.end_of_pairs;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        rate_board.predict_reply(it);
        if (it.kind == KIND_LOAD && 32'(it.first_index) < count_now && !loaded[it.first_index])
        begin
            loaded[it.first_index] = 1'b1;
            usable_q.push_back(32'(it.first_index));
        end
    endtask

    task automatic source_gap();
        if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Stops offering until every predicted reply has arrived, then lets the block settle.
    task automatic drain();
        req.valid <= 1'b0;
        while (rate_board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The particle count is only changed while the block is idle.
    task automatic write_count(input int unsigned value);
        int unsigned i;
        drain();
        cfg.valid          <= 1'b1;
        cfg.particle_count <= CNT_W'(value);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        rate_board.set_count(value);
        count_now = value;
        usable_q.delete();
        for (i = 0; i < MAX_PARTICLES_DEF; i++)
            if (loaded[IDX_W'(i)] && i < value)
                usable_q.push_back(i);
    endtask

    function automatic particle_item_t make_item(logic [KIND_W-1:0] kind, int unsigned a,
                                                 int unsigned b, logic [MASS_W-1:0] m,
                                                 logic signed [VEC_W-1:0] x,
                                                 logic signed [VEC_W-1:0] y,
                                                 logic signed [VEC_W-1:0] z, logic eop);
        particle_item_t it;
        it.kind         = kind;
        it.first_index  = IDX_W'(a);
        it.second_index = IDX_W'(b);
        it.mass         = m;
        it.vx           = x;
        it.vy           = y;
        it.vz           = z;
        it.end_of_pairs = eop;
        return it;
    endfunction

    // Mix of full-range, small, medium and extreme components, so that some pairs
    // saturate the accumulators while others accumulate meaningful sums.
    function automatic logic signed [VEC_W-1:0] pick_vector();
        logic signed [VEC_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = VEC_W'($urandom);
            1: v = VEC_W'($urandom_range(0, 1 << $urandom_range(0, 14)));
            2: v = VEC_W'($urandom_range(0, 1 << 18));
            default:
                case ($urandom_range(0, 3))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'h000001;
                    default: v = '0;
                endcase
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [MASS_W-1:0] pick_mass();
        case ($urandom_range(0, 3))
            0: return MASS_W'($urandom);
            1: return MASS_W'($urandom_range(0, 1 << 18));
            2: return 24'hFFFFFF;
            default: return MASS_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Most valid indices fall in a small window so that accumulators are hit repeatedly.
    function automatic int unsigned fresh_index();
        int unsigned idx;
        idx = window_base + $urandom_range(0, 23);
        if (idx >= count_now)
            idx = $urandom_range(0, count_now - 1);
        return idx;
    endfunction

    function automatic int unsigned flagged_index();
        return $urandom_range(count_now, MAX_PARTICLES_DEF - 1);
    endfunction

    function automatic int unsigned pick_loaded();
        return usable_q[$urandom_range(0, usable_q.size() - 1)];
    endfunction

    // Mostly well-formed traffic on loaded particles, with flagged indices and the
    // unused kind mixed in as noise.
    function automatic particle_item_t random_item();
        particle_item_t it;
        int unsigned    roll;
        bit             can_flag;
        can_flag        = count_now < MAX_PARTICLES_DEF;
        roll            = $urandom_range(0, 99);
        it.mass         = pick_mass();
        it.vx           = pick_vector();
        it.vy           = pick_vector();
        it.vz           = pick_vector();
        it.first_index  = IDX_W'($urandom);
        it.second_index = IDX_W'($urandom);
        it.end_of_pairs = ($urandom_range(0, 7) == 0);
        if (roll < 4)
            it.kind = KIND_UNUSED;
        else if (roll < 30 || usable_q.size() == 0)
        begin
            it.kind = KIND_LOAD;
            if (can_flag && $urandom_range(0, 4) == 0)
                it.first_index = IDX_W'(flagged_index());
            else if (usable_q.size() != 0 && $urandom_range(0, 1) == 0)
                it.first_index = IDX_W'(pick_loaded());
            else
                it.first_index = IDX_W'(fresh_index());
        end
        else if (roll < 78)
        begin
            it.kind         = KIND_PAIR;
            it.first_index  = IDX_W'(pick_loaded());
            it.second_index = ($urandom_range(0, 11) == 0) ? it.first_index
                                                             : IDX_W'(pick_loaded());
            if (can_flag && $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: it.first_index = IDX_W'(flagged_index());
                    1: it.second_index = IDX_W'(flagged_index());
                    default:
                    begin
                        it.first_index  = IDX_W'(flagged_index());
                        it.second_index = IDX_W'(flagged_index());
                    end
                endcase
            end
        end
        else
        begin
            it.kind = KIND_READ;
            if (can_flag && $urandom_range(0, 7) == 0)
                it.first_index = IDX_W'(flagged_index());
            else
                it.first_index = IDX_W'(pick_loaded());
        end
        return it;
    endfunction

    initial
    begin : stimulus
        int          phase;
        int          n;
        int unsigned plan_count [PHASES];
        int          plan_items [PHASES];

        req.valid            <= 1'b0;
        req.kind             <= '0;
        req.first_index      <= '0;
        req.second_index     <= '0;
        req.particle_mass_in <= '0;
        req.vector_x         <= '0;
        req.vector_y         <= '0;
        req.vector_z         <= '0;
        req.end_of_pairs     <= 1'b0;
        cfg.valid            <= 1'b0;
        cfg.particle_count   <= '0;
        count_now    = 32'(COUNT_RESET);
        window_base  = 0;
        gap_odds     = 0;
        quiet_tail   = 1'b0;
        hold_request = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the full particle count. Two particles with opposite extreme
        // velocities and full mass drive both accumulators into positive and then
        // negative saturation through a clamped product.
        write_count(MAX_PARTICLES_DEF);
        send_item(make_item(KIND_LOAD, 0, 0, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
        send_item(make_item(KIND_LOAD, 1023, 0, 24'hFFFFFF, 24'h800000, 24'h800000, 24'h800000,
                            1'b0));
        // A massless particle and one with the smallest nonzero mass.
        send_item(make_item(KIND_LOAD, 1, 1023, 24'h000000, 24'h000001, 24'h0, 24'h0, 1'b1));
        send_item(make_item(KIND_LOAD, 2, 0, 24'h000001, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 1023, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
        send_item(make_item(KIND_READ, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_READ, 1023, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 1023, 24'h0, 24'h800000, 24'h800000, 24'h800000, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 1023, 24'h0, 24'h800000, 24'h800000, 24'h800000, 1'b0));
        send_item(make_item(KIND_READ, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        // A dot product of minus one must floor to minus one, not round toward zero.
        send_item(make_item(KIND_PAIR, 1, 2, 24'h0, 24'hFFFFFF, 24'h0, 24'h0, 1'b1));
        send_item(make_item(KIND_READ, 1, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_READ, 2, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        // The same particle as both partners updates one accumulator twice.
        send_item(make_item(KIND_PAIR, 2, 2, 24'h0, 24'h123456, 24'hFFFFFB, 24'h7FFFFF, 1'b1));
        // The unused kind with every field set must change nothing and reply all zero.
        send_item(make_item(KIND_UNUSED, 1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            24'hFFFFFF, 1'b1));
        send_item(make_item(KIND_READ, 2, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_READ, 1023, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));

        // Smallest nonzero particle count: only index zero is valid. A flagged pair still
        // reports the end of the pair list.
        write_count(1);
        send_item(make_item(KIND_LOAD, 1, 0, 24'h00FFFF, 24'h000100, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 1, 24'h0, 24'h000100, 24'h0, 24'h0, 1'b1));
        send_item(make_item(KIND_READ, 1023, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_READ, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_LOAD, 0, 0, 24'h000005, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 0, 24'h0, 24'h000400, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_READ, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));

        // A count of zero flags every index.
        write_count(0);
        send_item(make_item(KIND_READ, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_LOAD, 0, 0, 24'h000001, 24'h0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(KIND_PAIR, 0, 0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1));

        // Random phases, each under its own particle count. The receiver long hold-off
        // falls in the first phase, one phase runs without source gaps, and the last
        // phase runs with no idling on either side.
        plan_count = '{MAX_PARTICLES_DEF, 2, $urandom_range(3, 1022), MAX_PARTICLES_DEF - 1,
                       $urandom_range(3, 1022), MAX_PARTICLES_DEF};
        plan_items = '{200, 100, 200, 150, 150, 150};
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_count(plan_count[phase]);
            window_base = $urandom_range(0, count_now - 1);
            quiet_tail  = (phase == PHASES - 1);
            gap_odds    = (phase == 3) ? 0 : $urandom_range(2, 6);
            for (n = 0; n < plan_items[phase]; n++)
            begin
                if (phase == 0 && n == 100)
                    hold_request = 1'b1;
                // The sender pauses once per phase, the last phase apart, until every reply is back.
                if (phase != PHASES - 1 && n == plan_items[phase] * 3 / 4)
                    drain();
                source_gap();
                send_item(random_item());
            end
        end

        // Wait for the outstanding replies, then a few more cycles so that a stray
        // extra reply would still be caught.
        drain();
        if (rate_board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
